// File: sv/fcal_pkg.sv
// Shared types and constants of the fixed-capacity array list.
// Holds the command codes, port widths and the controller/datapath structs.
// No dependencies.
package fcal_pkg;

  // Widths of the item fields and the config register
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned FIDX_W  = 4;
  localparam int unsigned MCNT_W  = 5;
  localparam int unsigned SIZE_W  = 5;

  // Reset value of the capacity limit register
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    OP_INSERT     = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_REMOVE_AT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_UPDATE     = 4'd4,
    OP_READ_AT    = 4'd5,
    OP_FIND_NTH   = 4'd6,
    OP_COUNT      = 4'd7,
    OP_REMOVE_NTH = 4'd8,
    OP_REMOVE_ALL = 4'd9,
    OP_CLEAR      = 4'd10
  } fcal_op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch the input item
    logic fwd_init;    // start a forward compaction / search pass
    logic fwd_step;    // advance the forward pass by one entry
    logic fwd_commit;  // take the new size after a removing pass
    logic bwd_init;    // start a backward shift for insert
    logic bwd_step;    // advance the backward shift by one entry
    logic rd_one;      // single read for read_at / pop_back
    logic take_data;   // capture the single read data
    logic put;         // write the item value at its slot
    logic clear;       // drop all elements
    logic mark_ok;     // result status is success
    logic out_load;    // load the result register
  } fcal_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             pos_lt_cnt;
    logic             pos_le_cnt;
    logic             full;
    logic             empty;
    logic             fwd_done;
    logic             bwd_done;
  } fcal_stat_t;

endpackage

// File: sv/fixed_capacity_array_list.sv
// Channel   | Signals                                              | Direction
// ----------+------------------------------------------------------+----------
// in        | in_valid_i/in_ready_o, command_i, position_i,        | input
//           | element_value_i, occurrence_i                        |
// out       | out_valid_o/out_ready_i, status_o, data_out_o,       | output
//           | found_index_o, match_count_o, size_now_o             |
// cfg       | cfg_valid_i/cfg_ready_o, capacity_limit_i            | input
//
// One item at a time. Insert, remove and search walk the element memory, one
// entry a cycle, and then drain the last read; update, clear and a failing
// check skip the walk, and read_at and pop_back take a single read. A
// finished result waits in the output register while the next item is
// accepted. Reset clears the size and sets the limit to 16; the element
// memory is not cleared. Config writes are taken every cycle.
module fixed_capacity_array_list import fcal_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] capacity_limit_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [DATA_W-1:0]  element_value_i,
  input  logic [OCC_W-1:0]   occurrence_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic [DATA_W-1:0]  data_out_o,
  output logic [FIDX_W-1:0]  found_index_o,
  output logic [MCNT_W-1:0]  match_count_o,
  output logic [SIZE_W-1:0]  size_now_o
);

  fcal_ctl_t  ctl;
  fcal_stat_t st;

  // Config register is always writable
  assign cfg_ready_o = 1'b1;

  fcal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  fcal_dp #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .capacity_limit_i(capacity_limit_i),
    .command_i       (command_i),
    .position_i      (position_i),
    .element_value_i (element_value_i),
    .occurrence_i    (occurrence_i),
    .ctl_i           (ctl),
    .st_o            (st),
    .status_o        (status_o),
    .data_out_o      (data_out_o),
    .found_index_o   (found_index_o),
    .match_count_o   (match_count_o),
    .size_now_o      (size_now_o)
  );

endmodule

// File: sv/fcal_dp.sv
// Datapath of the fixed-capacity array list: element memory, size, pointers,
// match logic and the result register. Driven by fcal_ctrl; uses fcal_pkg.
module fcal_dp import fcal_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [LIMIT_W-1:0] capacity_limit_i,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [DATA_W-1:0]  element_value_i,
  input  logic [OCC_W-1:0]   occurrence_i,
  input  fcal_ctl_t          ctl_i,
  output fcal_stat_t         st_o,
  output logic               status_o,
  output logic [DATA_W-1:0]  data_out_o,
  output logic [FIDX_W-1:0]  found_index_o,
  output logic [MCNT_W-1:0]  match_count_o,
  output logic [SIZE_W-1:0]  size_now_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned MW    = ((PW > OCC_W) ? PW : OCC_W) + 1;

  // Element store, no reset
  logic [ELEM_WIDTH-1:0] mem [CAPACITY];

  logic [CMD_W-1:0]      op_q;
  logic [POS_W-1:0]      pos_q;
  logic [ELEM_WIDTH-1:0] val_q;
  logic [OCC_W-1:0]      occ_q;
  logic [LIMIT_W-1:0]    limit_q;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      ptr_q;
  logic [CNT_W-1:0]      wr_q;
  logic [CNT_W-1:0]      matches_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [ELEM_WIDTH-1:0] rd_data_q;
  logic                  ok_q;
  logic [ELEM_WIDTH-1:0] data_q;
  logic [IDX_W-1:0]      fidx_q;

  logic                  status_q;
  logic [DATA_W-1:0]     data_out_q;
  logic [FIDX_W-1:0]     fidx_out_q;
  logic [MCNT_W-1:0]     mcnt_out_q;
  logic [SIZE_W-1:0]     size_q;

  logic [PW-1:0]         cnt_w, pos_w, lim_w, ptr_w, pos_eff_w, rd_idx_w;
  logic [CNT_W-1:0]      ptr_m1, cnt_m1, fwd_start;
  logic [MW-1:0]         next_match;
  logic                  is_rm, is_tally, match, hit, drop, keep_wr, one_taken;
  logic                  fwd_more, bwd_more;
  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;

  // Widen everything that is compared against the size
  assign cnt_w     = PW'(count_q);
  assign pos_w     = PW'(pos_q);
  assign lim_w     = PW'(limit_q);
  assign ptr_w     = PW'(ptr_q);
  assign rd_idx_w  = PW'(rd_idx_q);
  assign pos_eff_w = (op_q == OP_PUSH_BACK) ? cnt_w : pos_w;
  assign ptr_m1    = ptr_q - CNT_W'(1);
  assign cnt_m1    = count_q - CNT_W'(1);
  assign fwd_start = (op_q == OP_REMOVE_AT) ? CNT_W'(pos_q) : '0;

  assign is_rm    = (op_q == OP_REMOVE_AT) || (op_q == OP_REMOVE_NTH) ||
                    (op_q == OP_REMOVE_ALL);
  assign is_tally = (op_q == OP_COUNT) || (op_q == OP_REMOVE_ALL);

  // Match and drop decision on the entry returned by the last read
  assign match      = (rd_data_q == val_q);
  assign next_match = MW'(matches_q) + MW'(1);
  assign hit        = match && (next_match == MW'(occ_q));
  assign drop       = ((op_q == OP_REMOVE_ALL) && match) ||
                      ((op_q == OP_REMOVE_NTH) && hit) ||
                      ((op_q == OP_REMOVE_AT) && (rd_idx_w == pos_w));
  assign keep_wr    = ctl_i.fwd_step && rd_vld_q && is_rm && !drop;
  assign one_taken  = ctl_i.fwd_step && rd_vld_q &&
                      ((drop && (op_q != OP_REMOVE_ALL)) ||
                       ((op_q == OP_FIND_NTH) && hit));

  assign fwd_more = (ptr_w < cnt_w);
  assign bwd_more = (ptr_w > pos_eff_w);

  // Read port address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_q[IDX_W-1:0];
    if (ctl_i.fwd_step && fwd_more) begin
      rd_en   = 1'b1;
      rd_addr = ptr_q[IDX_W-1:0];
    end else if (ctl_i.bwd_step && bwd_more) begin
      rd_en   = 1'b1;
      rd_addr = ptr_m1[IDX_W-1:0];
    end else if (ctl_i.rd_one) begin
      rd_en   = 1'b1;
      rd_addr = (op_q == OP_POP_BACK) ? cnt_m1[IDX_W-1:0] : IDX_W'(pos_q);
    end
  end

  // Write port: value store, compaction or shift up
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IDX_W'(pos_eff_w);
    wr_data = val_q;
    if (ctl_i.put) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(pos_eff_w);
      wr_data = val_q;
    end else if (keep_wr) begin
      wr_en   = 1'b1;
      wr_addr = wr_q[IDX_W-1:0];
      wr_data = rd_data_q;
    end else if (ctl_i.bwd_step && rd_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_q + IDX_W'(1);
      wr_data = rd_data_q;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  // Control state: limit, size, read pipeline flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RST;
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cfg_valid_i) begin
        limit_q <= capacity_limit_i;
      end
      if (ctl_i.clear) begin
        count_q <= '0;
      end else if (ctl_i.rd_one && (op_q == OP_POP_BACK)) begin
        count_q <= cnt_m1;
      end else if (ctl_i.put && ((op_q == OP_INSERT) || (op_q == OP_PUSH_BACK))) begin
        count_q <= count_q + CNT_W'(1);
      end else if (ctl_i.fwd_commit && is_rm) begin
        count_q <= wr_q;
      end
    end
  end

  // Item fields, pass pointers and result fields
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q   <= command_i;
      pos_q  <= position_i;
      val_q  <= ELEM_WIDTH'(element_value_i);
      occ_q  <= occurrence_i;
      ok_q   <= 1'b0;
      data_q <= '0;
      fidx_q <= '0;
    end else begin
      if (ctl_i.mark_ok || one_taken) begin
        ok_q <= 1'b1;
      end
      if (ctl_i.take_data || (one_taken && (op_q != OP_FIND_NTH))) begin
        data_q <= rd_data_q;
      end
      if (one_taken && (op_q == OP_FIND_NTH)) begin
        fidx_q <= rd_idx_q;
      end
    end

    // Pass pointers
    if (ctl_i.fwd_init) begin
      ptr_q     <= fwd_start;
      wr_q      <= fwd_start;
      matches_q <= '0;
    end else if (ctl_i.bwd_init) begin
      ptr_q <= count_q;
    end else begin
      if (ctl_i.fwd_step && fwd_more) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end else if (ctl_i.bwd_step && bwd_more) begin
        ptr_q <= ptr_m1;
      end
      if (keep_wr) begin
        wr_q <= wr_q + CNT_W'(1);
      end
      if (ctl_i.fwd_step && rd_vld_q && match) begin
        matches_q <= matches_q + CNT_W'(1);
      end
    end

    // Result register
    if (ctl_i.out_load) begin
      status_q   <= !ok_q;
      data_out_q <= DATA_W'(data_q);
      fidx_out_q <= FIDX_W'(fidx_q);
      mcnt_out_q <= is_tally ? MCNT_W'(matches_q) : '0;
      size_q     <= SIZE_W'(count_q);
    end
  end

  // Status to the controller
  assign st_o.op         = op_q;
  assign st_o.pos_lt_cnt = (pos_w < cnt_w);
  assign st_o.pos_le_cnt = (pos_w <= cnt_w);
  assign st_o.full       = (cnt_w >= lim_w) || (cnt_w >= PW'(CAPACITY));
  assign st_o.empty      = (count_q == '0);
  assign st_o.fwd_done   = !fwd_more && !rd_vld_q;
  assign st_o.bwd_done   = !bwd_more && !rd_vld_q;

  assign status_o      = status_q;
  assign data_out_o    = data_out_q;
  assign found_index_o = fidx_out_q;
  assign match_count_o = mcnt_out_q;
  assign size_now_o    = size_q;

  // Size never runs past the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("size exceeds capacity");

  // The value write never collides with a read still in flight
  a_put_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.put |-> !rd_vld_q)
    else $error("put while read data pending");

endmodule

// File: sv/fcal_ctrl.sv
// Controller of the fixed-capacity array list: sequences each item through
// dispatch, memory passes and the result register. Uses fcal_pkg.
module fcal_ctrl import fcal_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  fcal_stat_t st_i,
  output fcal_ctl_t  ctl_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_FWD  = 3'd2;
  localparam logic [2:0] S_BWD  = 3'd3;
  localparam logic [2:0] S_RDW  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctl_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_FIN;
        unique case (st_i.op) inside
          OP_INSERT, OP_PUSH_BACK: begin
            if (!st_i.full && ((st_i.op == OP_PUSH_BACK) || st_i.pos_le_cnt)) begin
              ctl_o.bwd_init = 1'b1;
              state_d        = S_BWD;
            end
          end
          OP_REMOVE_AT: begin
            if (st_i.pos_lt_cnt) begin
              ctl_o.fwd_init = 1'b1;
              state_d        = S_FWD;
            end
          end
          OP_POP_BACK: begin
            if (!st_i.empty) begin
              ctl_o.rd_one  = 1'b1;
              ctl_o.mark_ok = 1'b1;
              state_d       = S_RDW;
            end
          end
          OP_READ_AT: begin
            if (st_i.pos_lt_cnt) begin
              ctl_o.rd_one  = 1'b1;
              ctl_o.mark_ok = 1'b1;
              state_d       = S_RDW;
            end
          end
          OP_UPDATE: begin
            if (st_i.pos_lt_cnt) begin
              ctl_o.put     = 1'b1;
              ctl_o.mark_ok = 1'b1;
            end
          end
          OP_FIND_NTH, OP_REMOVE_NTH: begin
            ctl_o.fwd_init = 1'b1;
            state_d        = S_FWD;
          end
          OP_COUNT, OP_REMOVE_ALL: begin
            ctl_o.fwd_init = 1'b1;
            ctl_o.mark_ok  = 1'b1;
            state_d        = S_FWD;
          end
          OP_CLEAR: begin
            ctl_o.clear   = 1'b1;
            ctl_o.mark_ok = 1'b1;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_FWD: begin
        if (st_i.fwd_done) begin
          ctl_o.fwd_commit = 1'b1;
          state_d          = S_FIN;
        end else begin
          ctl_o.fwd_step = 1'b1;
        end
      end
      S_BWD: begin
        if (st_i.bwd_done) begin
          ctl_o.put     = 1'b1;
          ctl_o.mark_ok = 1'b1;
          state_d       = S_FIN;
        end else begin
          ctl_o.bwd_step = 1'b1;
        end
      end
      S_RDW: begin
        ctl_o.take_data = 1'b1;
        state_d         = S_FIN;
      end
      S_FIN: begin
        // Hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted item always goes to dispatch next
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISP))
    else $error("accepted item not dispatched");

  // A blocked result keeps the finished item waiting
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_ready_i) |=> (state_q == S_FIN))
    else $error("finished item left while result blocked");

  // A new result only appears from the finish step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.out_load) |-> (state_q == S_FIN && (!out_valid_q || out_ready_i)))
    else $error("result loaded outside finish");

endmodule
